>>> hw/rtl/tvdt_pkg.sv
// ----------------------------------------------------------------------------
// tvdt_pkg
// Shared types, constants and keyword tables for the decimal text renderer.
// ----------------------------------------------------------------------------
package tvdt_pkg;

  localparam int WordW     = 64;
  localparam int MaxDigits = 20;
  localparam int DigitW    = 4;
  localparam int BcdW      = MaxDigits * DigitW;
  localparam int CharW     = 8;

  localparam logic [2:0]       TagMask   = 3'h7;
  localparam logic [2:0]       TagInt    = 3'h0;
  localparam logic [2:0]       TagHeap   = 3'h1;
  localparam logic [WordW-1:0] WordNil   = 64'h3;
  localparam logic [WordW-1:0] WordTrue  = 64'hB;
  localparam logic [WordW-1:0] WordFalse = 64'h13;

  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharNone  = 8'h00;
  localparam logic [3:0]       DigitHigh = 4'h3;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_KEYWORD,
    KIND_HEAP
  } kind_e;

  typedef enum logic [1:0] {
    KW_NIL,
    KW_TRUE,
    KW_FALSE,
    KW_VALUE
  } kw_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS,
    ST_KEYW,
    ST_HEAP
  } state_e;

  typedef struct packed {
    kind_e            kind;
    logic             neg;
    logic [WordW-1:0] mag;
    kw_e              kw;
  } cmd_t;

  // Index of the final character of each keyword.
  function automatic logic [2:0] kw_last_idx(kw_e kw);
    logic [2:0] r;
    unique case (kw)
      KW_NIL:   r = 3'd2;
      KW_TRUE:  r = 3'd3;
      KW_FALSE: r = 3'd4;
      default:  r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] kw_char(kw_e kw, logic [2:0] idx);
    logic [CharW-1:0] c;
    c = CharNone;
    unique case (kw)
      KW_NIL: begin
        case (idx)
          3'd0:    c = "n";
          3'd1:    c = "i";
          default: c = "l";
        endcase
      end
      KW_TRUE: begin
        case (idx)
          3'd0:    c = "t";
          3'd1:    c = "r";
          3'd2:    c = "u";
          default: c = "e";
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0:    c = "f";
          3'd1:    c = "a";
          3'd2:    c = "l";
          3'd3:    c = "s";
          default: c = "e";
        endcase
      end
      default: begin
        case (idx)
          3'd0:    c = "<";
          3'd1:    c = "v";
          3'd2:    c = "a";
          3'd3:    c = "l";
          3'd4:    c = "u";
          3'd5:    c = "e";
          default: c = ">";
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/tvdt_front.sv
// ----------------------------------------------------------------------------
// tvdt_front
// Accepts input words, classifies them and pushes one render request.
// ----------------------------------------------------------------------------
module tvdt_front
  import tvdt_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  logic [WordW-1:0] word_i,
  input  logic             full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [WordW-1:0] shifted;
  logic [2:0]       tag;

  assign tag        = word_i[2:0] & TagMask;
  assign shifted    = {{3{word_i[WordW-1]}}, word_i[WordW-1:3]};
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.kind = KIND_KEYWORD;
    cmd_o.neg  = 1'b0;
    cmd_o.mag  = word_i;
    cmd_o.kw   = KW_VALUE;
    if (mode_i) begin
      cmd_o.kind = KIND_NUM;
    end else if (tag == TagInt) begin
      cmd_o.kind = KIND_NUM;
      cmd_o.neg  = word_i[WordW-1];
      // magnitude of the shifted value, at most 2^60
      cmd_o.mag  = word_i[WordW-1] ? (~shifted + 1'b1) : shifted;
    end else if (tag == TagHeap && word_i[WordW-1:3] != '0) begin
      cmd_o.kind = KIND_HEAP;
    end else if (word_i == WordNil) begin
      cmd_o.kw = KW_NIL;
    end else if (word_i == WordTrue) begin
      cmd_o.kw = KW_TRUE;
    end else if (word_i == WordFalse) begin
      cmd_o.kw = KW_FALSE;
    end
  end

endmodule

>>> hw/rtl/tvdt_fifo.sv
// ----------------------------------------------------------------------------
// tvdt_fifo
// Short request queue between the classifier and the render engine.
// ----------------------------------------------------------------------------
module tvdt_fifo
  import tvdt_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  cmd_t          slot_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> hw/rtl/tvdt_back.sv
// ----------------------------------------------------------------------------
// tvdt_back
// Render engine: bit-serial binary to BCD conversion and character output.
// ----------------------------------------------------------------------------
module tvdt_back
  import tvdt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] text_char_o,
  output logic             last_char_o,
  output logic             heap_ref_o
);

  state_e           state_q, state_d;
  logic [WordW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [BcdW-1:0]  bcd_adj;
  logic [5:0]       cnt_q, cnt_d;
  logic [4:0]       ndig_q, ndig_d;
  logic [2:0]       idx_q, idx_d;
  logic             neg_q, neg_d;
  kw_e              kw_q, kw_d;

  logic             ov_q, ov_d;
  logic [CharW-1:0] ch_q, ch_d;
  logic             last_q, last_d;
  logic             heap_q, heap_d;

  logic             can_emit;
  logic             emit;
  logic [DigitW-1:0] top_digit;

  assign can_emit  = !ov_q || !out_stall_i;
  assign top_digit = bcd_q[BcdW-1 -: DigitW];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      bcd_adj[i*DigitW +: DigitW] = (bcd_q[i*DigitW +: DigitW] >= 4'd5) ?
          bcd_q[i*DigitW +: DigitW] + 4'd3 : bcd_q[i*DigitW +: DigitW];
    end
  end

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    ndig_d  = ndig_q;
    idx_d   = idx_q;
    neg_d   = neg_q;
    kw_d    = kw_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    ch_d    = ch_q;
    last_d  = 1'b0;
    heap_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          bin_d = cmd_i.mag;
          bcd_d = '0;
          cnt_d = '0;
          neg_d = cmd_i.neg;
          kw_d  = cmd_i.kw;
          idx_d = '0;
          unique case (cmd_i.kind)
            KIND_NUM:     state_d = ST_CONV;
            KIND_HEAP:    state_d = ST_HEAP;
            default:      state_d = ST_KEYW;
          endcase
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[WordW-1]};
        bin_d = {bin_q[WordW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(WordW - 1)) begin
          ndig_d  = 5'(MaxDigits);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == '0 && ndig_q != 5'd1) begin
          bcd_d  = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (can_emit) begin
          emit    = 1'b1;
          ch_d    = CharMinus;
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (can_emit) begin
          emit   = 1'b1;
          ch_d   = {DigitHigh, top_digit};
          last_d = (ndig_q == 5'd1);
          bcd_d  = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          ndig_d = ndig_q - 1'b1;
          if (ndig_q == 5'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_KEYW: begin
        if (can_emit) begin
          emit   = 1'b1;
          ch_d   = kw_char(kw_q, idx_q);
          last_d = (idx_q == kw_last_idx(kw_q));
          idx_d  = idx_q + 1'b1;
          if (idx_q == kw_last_idx(kw_q)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_HEAP: begin
        if (can_emit) begin
          emit    = 1'b1;
          ch_d    = CharNone;
          last_d  = 1'b1;
          heap_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit) begin
      ov_d = 1'b1;
    end else begin
      ov_d = ov_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
    idx_q  <= idx_d;
    neg_q  <= neg_d;
    kw_q   <= kw_d;
    if (emit) begin
      ch_q   <= ch_d;
      last_q <= last_d;
      heap_q <= heap_d;
    end
  end

  assign out_valid_o = ov_q;
  assign text_char_o = ch_q;
  assign last_char_o = last_q;
  assign heap_ref_o  = heap_q;

  a_heap_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && heap_q |-> last_q)
    else $error("heap reference result without last marker");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGITS |-> top_digit <= 4'd9 && ndig_q != 5'd0)
    else $error("invalid BCD digit or digit count at output");

  a_sign_only_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIGN |-> neg_q)
    else $error("minus sign for a non-negative value");

  a_pop_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE && !empty_i)
    else $error("request taken while engine busy");

endmodule

>>> hw/rtl/tagged_value_to_decimal_text_core.sv
// ----------------------------------------------------------------------------
// tagged_value_to_decimal_text_core
// Renders a 64-bit raw or tagged word as ASCII decimal or keyword text.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one request carries mode_i and
// word_i. A classifier turns it into a render request and places it in a
// short queue, so new words are taken while the engine is still busy.
// Output channel (out_valid_o / out_stall_i): one ASCII character per
// transfer, most significant first, last_char_o on the final one. A heap
// reference gives a single transfer with heap_ref_o set and no text.
// Per number: the engine dequeues the request, runs the bit-serial BCD
// conversion, drops each leading zero digit in turn and leaves the skip
// step, then emits one character per cycle while the output does not
// stall. Keywords are dequeued and emit one character per cycle likewise;
// a heap reference is dequeued and gives its one transfer. A new request
// is taken only from idle; the 64-step shift-and-add-3 loop sets the rate.
// Reset clears the queue and the engine; no item is pending afterwards.
// A stalled output holds its character; the engine waits, the queue fills,
// and then in_stall_o rises.
// ----------------------------------------------------------------------------
module tagged_value_to_decimal_text_core
  import tvdt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  logic [WordW-1:0] word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] text_char_o,
  output logic             last_char_o,
  output logic             heap_ref_o
);

  logic push, pop, full, empty;
  cmd_t cmd_in, cmd_out;

  tvdt_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .word_i     (word_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  tvdt_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  tvdt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o),
    .heap_ref_o  (heap_ref_o)
  );

endmodule

>>> tb/tb_tagged_value_to_decimal_text_core.sv
// ----------------------------------------------------------------------------
// tb_tagged_value_to_decimal_text_core
// Drives raw and tagged words into the renderer and checks every character,
// last marker and heap flag against a predicted text queue. Both sides idle
// at random; one stretch runs with no idling and the sender drains midway and at the end.
// ----------------------------------------------------------------------------
module tb_tagged_value_to_decimal_text_core;
  import tvdt_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomWords = 150;
  localparam int IdlePct     = 29;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
    logic             heap;
  } char_rec_t;

  class text_scoreboard;
    char_rec_t expected_chars[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void push_text(logic [CharW-1:0] text[$]);
      char_rec_t r;
      foreach (text[i]) begin
        r.ch   = text[i];
        r.last = (i == text.size() - 1);
        r.heap = 1'b0;
        expected_chars.push_back(r);
      end
    endfunction

    function void push_keyword(string s);
      logic [CharW-1:0] text[$];
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      push_text(text);
    endfunction

    // Most significant digit first, optional minus in front.
    function void push_decimal(logic [WordW-1:0] v, logic neg);
      logic [CharW-1:0] text[$];
      if (v == '0) text.push_back("0");
      while (v != '0) begin
        text.push_front(8'h30 + CharW'(v % 64'd10));
        v = v / 64'd10;
      end
      if (neg) text.push_front(CharMinus);
      push_text(text);
    endfunction

    function void note_request(logic mode, logic [WordW-1:0] word);
      logic [WordW-1:0] mag;
      char_rec_t        r;
      if (mode) begin
        push_decimal(word, 1'b0);
      end else if (word[2:0] == TagInt) begin
        mag = word >> 3;
        if (word[WordW-1]) begin
          mag = ~(mag | 64'hE000_0000_0000_0000) + 64'd1;
          push_decimal(mag, 1'b1);
        end else begin
          push_decimal(mag, 1'b0);
        end
      end else if (word[2:0] == TagHeap && word[WordW-1:3] != '0) begin
        r.ch   = CharNone;
        r.last = 1'b1;
        r.heap = 1'b1;
        expected_chars.push_back(r);
      end else if (word == WordTrue) begin
        push_keyword("true");
      end else if (word == WordFalse) begin
        push_keyword("false");
      end else if (word == WordNil) begin
        push_keyword("nil");
      end else begin
        push_keyword("<value>");
      end
    endfunction

    function void check_char(logic [CharW-1:0] ch, logic last, logic heap);
      char_rec_t e;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: text_char %h last_char %b heap_ref %b",
               ch, last, heap);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch) begin
        $error("text_char: expected %h actual %h", e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_char: expected %b actual %b", e.last, last);
        errors++;
      end
      if (heap !== e.heap) begin
        $error("heap_ref: expected %b actual %b", e.heap, heap);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             mode_i      = 1'b0;
  logic [WordW-1:0] word_i      = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [CharW-1:0] text_char_o;
  logic             last_char_o;
  logic             heap_ref_o;

  text_scoreboard sb;
  bit             steady = 1'b0;
  int             cycle_count = 0;

  tagged_value_to_decimal_text_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .word_i      (word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o),
    .heap_ref_o  (heap_ref_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tagged_value_to_decimal_text_core: mismatch");
      $finish;
    end
  end

  // Sample both channels with the values that held before this edge.
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) sb.note_request(mode_i, word_i);
      if (out_valid_o && !out_stall_i) sb.check_char(text_char_o, last_char_o, heap_ref_o);
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
  end

  task automatic send_request(input logic m, input logic [WordW-1:0] w);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    word_i     <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_random();
    logic [WordW-1:0] w;
    logic             m;
    w = rand_word();
    m = 1'b0;
    case ($urandom_range(0, 9))
      0, 1: m = 1'b1;
      2:    begin m = 1'b1; w = w >> $urandom_range(0, 63); end
      3, 4: w[2:0] = TagInt;
      5:    begin w = w >> $urandom_range(0, 63); w[2:0] = TagInt; end
      6:    begin w = -(w >> $urandom_range(3, 63)); w[2:0] = TagInt; end
      7:    begin w[2:0] = TagHeap; if ($urandom_range(0, 3) == 0) w = 64'h1; end
      8: begin
        case ($urandom_range(0, 2))
          0:       w = WordNil;
          1:       w = WordTrue;
          default: w = WordFalse;
        endcase
        m = $urandom_range(0, 3) == 0;
      end
      default: ;
    endcase
    send_request(m, w);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // raw extremes and digit-count boundaries
    send_request(1'b1, 64'd0);
    send_request(1'b1, 64'd1);
    send_request(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(1'b1, 64'd10000000000000000000);
    send_request(1'b1, 64'd9999999999999999999);
    send_request(1'b1, WordTrue);
    // tagged integers: zero, one, largest, minus one, most negative
    send_request(1'b0, 64'h0);
    send_request(1'b0, 64'h8);
    send_request(1'b0, 64'h7FFF_FFFF_FFFF_FFF8);
    send_request(1'b0, 64'hFFFF_FFFF_FFFF_FFF8);
    send_request(1'b0, 64'h8000_0000_0000_0000);
    // keywords and near misses
    send_request(1'b0, WordNil);
    send_request(1'b0, WordTrue);
    send_request(1'b0, WordFalse);
    send_request(1'b0, 64'h1B);
    // heap references and the null heap pointer
    send_request(1'b0, 64'h9);
    send_request(1'b0, 64'hFFFF_FFFF_FFFF_FFF9);
    send_request(1'b0, 64'h1);
    // remaining tags fall to the generic text
    send_request(1'b0, 64'h2);
    send_request(1'b0, 64'h4);
    send_request(1'b0, 64'h5);
    send_request(1'b0, 64'h6);
    send_request(1'b0, 64'h7);
    send_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);

    for (int i = 0; i < RandomWords; i++) begin
      if (i == 40) wait_drained();
      steady = (i >= 90 && i < 130);
      send_random();
    end
    steady = 1'b0;

    wait_drained();
    repeat (120) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tagged_value_to_decimal_text_core: match");
    end else begin
      $display("tagged_value_to_decimal_text_core: mismatch");
    end
    $finish;
  end

endmodule
